FILE: sv/pwmc_pkg.sv
package pwmc_pkg;

  // divider operand width, wide enough for the pulse width and phase dividends
  localparam int unsigned DivWidth = 68;
  localparam int unsigned MulAWidth = 32;
  localparam int unsigned MulBWidth = 18;
  localparam int unsigned MulPWidth = MulAWidth + MulBWidth;

  localparam logic [31:0] CoreClockReset = 32'd48000000;
  localparam logic [17:0] FullTurnQ8 = 18'd92160;
  localparam logic [17:0] PrescaleDiv = 18'd131069;
  localparam logic [34:0] PhaseMax = 35'd92159;
  localparam logic [32:0] DutyMax = 33'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_DIV_P,
    ST_MUL_FP,
    ST_DIV_Q,
    ST_MUL_CD,
    ST_DIV_PW,
    ST_MUL_PHC,
    ST_DIV_PC,
    ST_MUL_PQ,
    ST_DIV_AF,
    ST_DIV_AD,
    ST_MUL_X,
    ST_DIV_X,
    ST_FIN
  } state_t;

endpackage

FILE: sv/pwmc_mul.sv
module pwmc_mul (
  input  logic                            clk,
  input  logic [pwmc_pkg::MulAWidth-1:0]  a,
  input  logic [pwmc_pkg::MulBWidth-1:0]  b,
  output logic [pwmc_pkg::MulPWidth-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= pwmc_pkg::MulPWidth'(a) * pwmc_pkg::MulPWidth'(b);
  end

endmodule

FILE: sv/pwmc_div.sv
module pwmc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pwmc_pkg::DivWidth-1:0]  dividend,
  input  logic [pwmc_pkg::DivWidth-1:0]  divisor,
  output logic                           busy,
  output logic                           done,
  output logic [pwmc_pkg::DivWidth-1:0]  quotient
);

  localparam int unsigned DW = pwmc_pkg::DivWidth;
  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quo[DW-1]};
  assign diff = rem_sh - {1'b0, dvs};
  assign ge = (rem_sh >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo <= {quo[DW-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: sv/pwm_timer_setting_calculator_top.sv
// pwm timer setting calculator
// one request on the s_axis side carries a channel's frequency, duty, phase and
// enable; one result on the m_axis side carries the prescaler, period, pulse
// width and phase registers plus the frequency, duty and phase achieved.
// core_clock_hz is written through cfg_wr_en / cfg_wr_data; write it only while
// idle, as the block itself does not enforce it. all quotients run on one shared
// restoring divider (one quotient bit a cycle, 68 bits) fed by one registered
// 32x18 multiplier under a small sequencer. a request takes up to seven
// divisions and six multiplies; a period count of zero ends after four
// divisions, of one after five, and a zero frequency skips them all.
// s_axis_tready is high only while the sequencer is idle.
// the result sits in an output register; a new request is taken while it waits,
// and the sequencer holds its last step until the receiver takes the old one.
// reset clears the sequencer and output valid and sets the clock to 48 MHz.
module pwm_timer_setting_calculator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // enabled[0], freq_hz[32:1], duty_q16[48:33], phase_q8[66:49], zero fill
  input  logic [71:0]  s_axis_tdata,
  // channel[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mode_pwm[0], prescaler_minus_one[16:1], period_minus_one[32:17],
  // pulse_width_count[48:33], phase_count[64:49], actual_freq_hz[96:65],
  // actual_duty_q16[114:97], actual_phase_q8[132:115], range_error[133], zero fill
  output logic [135:0] m_axis_tdata,
  // channel_out[1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned DW = pwmc_pkg::DivWidth;

  pwmc_pkg::state_t state, state_next;

  logic [31:0] core_clock_hz;
  logic [1:0]  ch;
  logic        en;
  logic [31:0] f;
  logic [15:0] d;
  logic [17:0] ph;
  logic        zf;
  logic [16:0] p;
  logic [48:0] fp;
  logic [DW-1:0] fp92;
  logic [15:0] q;
  logic [15:0] pw;
  logic [15:0] pc;
  logic [31:0] afreq;
  logic [17:0] aduty;
  logic [32:0] x;
  logic        issued;

  logic [31:0] mul_a;
  logic [17:0] mul_b;
  logic [pwmc_pkg::MulPWidth-1:0] prod;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_busy;
  logic          div_done;
  logic [DW-1:0] quo;

  logic          in_acc;
  logic          out_free;
  logic [17:0]   praw;
  logic [15:0]   pr;
  logic [DW-1:0] fpx;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign praw = s_axis_tdata[66:49];
  assign pr = q - 1'b1;
  assign fpx = DW'(prod[48:0]);

  pwmc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pwmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz <= pwmc_pkg::CoreClockReset;
    end else if (cfg_wr_en) begin
      core_clock_hz <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pwmc_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (div_start) begin
        issued <= 1'b1;
      end else if (div_done) begin
        issued <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pwmc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (s_axis_tdata[32:1] == '0) ? pwmc_pkg::ST_FIN : pwmc_pkg::ST_MUL_P;
        end
      end
      pwmc_pkg::ST_MUL_P:   state_next = pwmc_pkg::ST_DIV_P;
      pwmc_pkg::ST_DIV_P:   if (div_done) state_next = pwmc_pkg::ST_MUL_FP;
      pwmc_pkg::ST_MUL_FP:  state_next = pwmc_pkg::ST_DIV_Q;
      pwmc_pkg::ST_DIV_Q:   if (div_done) state_next = pwmc_pkg::ST_MUL_CD;
      pwmc_pkg::ST_MUL_CD:  state_next = pwmc_pkg::ST_DIV_PW;
      pwmc_pkg::ST_DIV_PW:  if (div_done) state_next = pwmc_pkg::ST_MUL_PHC;
      pwmc_pkg::ST_MUL_PHC: state_next = pwmc_pkg::ST_DIV_PC;
      pwmc_pkg::ST_DIV_PC: begin
        if (div_done) begin
          state_next = (q != '0) ? pwmc_pkg::ST_MUL_PQ : pwmc_pkg::ST_FIN;
        end
      end
      pwmc_pkg::ST_MUL_PQ:  state_next = pwmc_pkg::ST_DIV_AF;
      pwmc_pkg::ST_DIV_AF: begin
        if (div_done) begin
          state_next = (q > 16'd1) ? pwmc_pkg::ST_DIV_AD : pwmc_pkg::ST_FIN;
        end
      end
      pwmc_pkg::ST_DIV_AD:  if (div_done) state_next = pwmc_pkg::ST_MUL_X;
      pwmc_pkg::ST_MUL_X:   state_next = pwmc_pkg::ST_DIV_X;
      pwmc_pkg::ST_DIV_X:   if (div_done) state_next = pwmc_pkg::ST_FIN;
      pwmc_pkg::ST_FIN:     if (out_free) state_next = pwmc_pkg::ST_IDLE;
      default:              state_next = pwmc_pkg::ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    s_axis_tready = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_dividend = '0;
    div_divisor = '0;
    div_start = 1'b0;
    case (state)
      pwmc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      pwmc_pkg::ST_MUL_P: begin
        mul_a = f;
        mul_b = pwmc_pkg::PrescaleDiv;
      end
      pwmc_pkg::ST_DIV_P: begin
        div_start = !issued;
        div_dividend = DW'({core_clock_hz, 1'b0});
        div_divisor = DW'(prod);
      end
      pwmc_pkg::ST_MUL_FP: begin
        mul_a = f;
        mul_b = {1'b0, p};
      end
      pwmc_pkg::ST_DIV_Q: begin
        div_start = !issued;
        div_dividend = DW'({core_clock_hz, 1'b0}) + fpx;
        div_divisor = fpx << 1;
      end
      pwmc_pkg::ST_MUL_CD: begin
        mul_a = core_clock_hz;
        mul_b = {2'b00, d};
      end
      pwmc_pkg::ST_DIV_PW: begin
        div_start = !issued;
        div_dividend = DW'(prod) + (DW'(fp) << 16) - DW'(1);
        div_divisor = DW'(fp) << 16;
      end
      pwmc_pkg::ST_MUL_PHC: begin
        mul_a = core_clock_hz;
        mul_b = ph;
      end
      pwmc_pkg::ST_DIV_PC: begin
        div_start = !issued;
        div_dividend = (DW'(prod) << 1) + fp92;
        div_divisor = fp92 << 1;
      end
      pwmc_pkg::ST_MUL_PQ: begin
        mul_a = 32'(p);
        mul_b = {2'b00, q};
      end
      pwmc_pkg::ST_DIV_AF: begin
        div_start = !issued;
        div_dividend = DW'(core_clock_hz);
        div_divisor = DW'(prod[32:0]);
      end
      pwmc_pkg::ST_DIV_AD: begin
        div_start = !issued;
        div_dividend = DW'({pw, 16'h0000});
        div_divisor = DW'(pr);
      end
      pwmc_pkg::ST_MUL_X: begin
        mul_a = 32'(pc);
        mul_b = pwmc_pkg::FullTurnQ8;
      end
      pwmc_pkg::ST_DIV_X: begin
        div_start = !issued;
        div_dividend = DW'(prod[32:0]);
        div_divisor = DW'(pr);
      end
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch <= s_axis_tuser;
      en <= s_axis_tdata[0];
      f <= s_axis_tdata[32:1];
      d <= s_axis_tdata[48:33];
      // negative phase wraps once by a full turn
      ph <= praw[17] ? praw + pwmc_pkg::FullTurnQ8 : praw;
      zf <= (s_axis_tdata[32:1] == '0);
    end
    if (state == pwmc_pkg::ST_DIV_Q && div_start) begin
      fp <= prod[48:0];
    end
    if (state == pwmc_pkg::ST_MUL_CD) begin
      // fp times 92160 as shifts
      fp92 <= (DW'(fp) << 16) + (DW'(fp) << 14) + (DW'(fp) << 13) + (DW'(fp) << 11);
    end
    if (div_done) begin
      case (state)
        pwmc_pkg::ST_DIV_P:  p <= quo[16:0] + 17'd1;
        pwmc_pkg::ST_DIV_Q:  q <= quo[15:0];
        pwmc_pkg::ST_DIV_PW: pw <= (|quo[DW-1:16]) ? 16'hFFFF : quo[15:0];
        pwmc_pkg::ST_DIV_PC: pc <= (|quo[DW-1:16]) ? 16'hFFFF : quo[15:0];
        pwmc_pkg::ST_DIV_AF: afreq <= quo[31:0];
        pwmc_pkg::ST_DIV_AD: begin
          aduty <= (quo > DW'(pwmc_pkg::DutyMax)) ? pwmc_pkg::DutyMax[17:0] : quo[17:0];
        end
        pwmc_pkg::ST_DIV_X:  x <= quo[32:0];
        default: ;
      endcase
    end
  end

  // result assembly
  logic        p_big;
  logic        q_small;
  logic [34:0] aph_raw;
  logic [34:0] aph_sat;
  logic [15:0] presc_o;
  logic [15:0] period_o;
  logic [31:0] afreq_o;
  logic [17:0] aduty_o;
  logic [17:0] aphase_o;
  logic        err_o;

  always_comb begin
    p_big = p[16] && (p[15:0] != '0);
    q_small = (q <= 16'd1);
    // phase above half a turn folds negative
    aph_raw = ({pc, 1'b0} > {1'b0, pr}) ? (35'(x) - 35'(pwmc_pkg::FullTurnQ8)) : 35'(x);
    aph_sat = (!aph_raw[34] && aph_raw > pwmc_pkg::PhaseMax) ? pwmc_pkg::PhaseMax : aph_raw;
    presc_o = p_big ? 16'hFFFF : 16'(p - 17'd1);
    period_o = (q == '0) ? 16'h0000 : pr;
    afreq_o = (q == '0) ? 32'h0 : afreq;
    aduty_o = q_small ? 18'h0 : aduty;
    aphase_o = q_small ? 18'h0 : aph_sat[17:0];
    err_o = p_big || q_small;
    if (zf) begin
      presc_o = '0;
      period_o = '0;
      afreq_o = '0;
      aduty_o = '0;
      aphase_o = '0;
      err_o = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == pwmc_pkg::ST_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pwmc_pkg::ST_FIN && out_free) begin
      m_axis_tuser <= ch;
      m_axis_tdata <= {2'b00, err_o, aphase_o, aduty_o, afreq_o,
                       (zf ? 16'h0000 : pc), (zf ? 16'h0000 : pw),
                       period_o, presc_o, en};
    end
  end

endmodule
